// ----- sv/tte_pkg.sv -----
// Shared types and constants for the tap tempo estimator.
package tte_pkg;

  localparam int STAMP_W = 32;
  localparam int GAP_W   = 16;
  localparam int TEMPO_W = 10;
  localparam int HELD_W  = 3;
  localparam int STAT_W  = 2;
  localparam int OUT_W   = 16;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [15:0] BPM_NUM = 16'd60000;

  localparam logic [GAP_W-1:0]   GAP_RST = 16'd2500;
  localparam logic [TEMPO_W-1:0] MIN_RST = 10'd40;
  localparam logic [TEMPO_W-1:0] MAX_RST = 10'd300;

  localparam logic [1:0] REG_GAP = 2'd0;
  localparam logic [1:0] REG_MIN = 2'd1;
  localparam logic [1:0] REG_MAX = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GAP_RD,
    S_GAP_CHK,
    S_WRITE,
    S_FIRST_RD,
    S_FIRST_CHK,
    S_DIV,
    S_DONE
  } tte_state_t;

  typedef enum logic [STAT_W-1:0] {
    TS_WAIT  = 2'd0,
    TS_TEMPO = 2'd1,
    TS_ZERO  = 2'd2
  } tap_status_t;

endpackage

// ----- sv/tte_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
module tte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/tte_div.sv -----
// Restoring shift-subtract divider, one quotient bit per cycle.
module tte_div #(
  parameter int NUM_W = 18,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quot,
  output logic             done
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] qr_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, qr_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      qr_r  <= num;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      qr_r  <= {qr_r[NUM_W-2:0], ge};
    end
  end

  assign quot = qr_r;
  assign done = done_r;

endmodule

// ----- sv/tap_tempo_estimator_core.sv -----
// Tap tempo estimator top level: tap ring, sequencer, divider and register port.
// Per tap: gap check against the previous stamp when one is held, stamp write,
// then, once three taps are counted, an oldest-stamp read and a serial divide
// unless that span is zero; the next tap is taken after the result is loaded.
// Reset: synchronous active-low rst_n clears history count, ring slot and
// registers to their defaults; the stamp ring itself is not cleared.
module tap_tempo_estimator_core #(
  parameter int TAP_WINDOW = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [tte_pkg::STAMP_W-1:0]  in_tdata,   // [31:0] tap_time_ms
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [tte_pkg::OUT_W-1:0]    out_tdata,  // [1:0] tap_status, [11:2] tempo_bpm,
                                                   // [14:12] taps_held, [15] constant 0
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [tte_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [tte_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [tte_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                         cfg_pready
);

  import tte_pkg::*;

  localparam int SW    = $clog2(TAP_WINDOW);
  localparam int CAP   = (TAP_WINDOW < 3) ? 3 : TAP_WINDOW;
  localparam int TW    = $clog2(CAP + 1);
  localparam int HW    = $clog2(TAP_WINDOW + 1);
  localparam int NUM_W = $clog2(60000 * (TAP_WINDOW - 1) + 1);

  tte_state_t state_r, state_nxt;

  logic [GAP_W-1:0]   gap_to_r;
  logic [TEMPO_W-1:0] tmin_r;
  logic [TEMPO_W-1:0] tmax_r;

  logic [SW-1:0]      slot_r;
  logic [TW-1:0]      total_r;
  logic [TW-1:0]      total_inc;
  logic [HW-1:0]      held_r;
  logic [STAMP_W-1:0] now_r;
  logic [NUM_W-1:0]   num_r;
  tap_status_t        status_r;
  logic [TEMPO_W-1:0] bpm_r;

  logic               out_tvalid_r;
  logic [OUT_W-1:0]   out_tdata_r;

  logic [STAMP_W-1:0] rd_data;
  logic [SW-1:0]      rd_addr;
  logic               wr_en;
  logic [HW-1:0]      back_k;
  logic [SW:0]        back_sum;
  logic [STAMP_W-1:0] delta;
  logic               gap_over;
  logic               div_start;
  logic               div_done;
  logic [NUM_W-1:0]   div_q;
  logic [NUM_W-1:0]   q_lo;
  logic [NUM_W-1:0]   q_clamp;
  logic               out_load;
  logic               cfg_wr;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_to_r <= GAP_RST;
      tmin_r   <= MIN_RST;
      tmax_r   <= MAX_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_GAP: gap_to_r <= cfg_pwdata[GAP_W-1:0];
        REG_MIN: tmin_r   <= cfg_pwdata[TEMPO_W-1:0];
        REG_MAX: tmax_r   <= cfg_pwdata[TEMPO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_GAP: cfg_prdata = DATA_W'(gap_to_r);
      REG_MIN: cfg_prdata = DATA_W'(tmin_r);
      REG_MAX: cfg_prdata = DATA_W'(tmax_r);
      default: cfg_prdata = '0;
    endcase
  end

  // Ring index arithmetic: slot minus k modulo the window
  assign back_k   = (state_r == S_GAP_RD) ? HW'(1) : held_r;
  assign back_sum = {1'b0, slot_r} + (SW+1)'(TAP_WINDOW) - (SW+1)'(back_k);
  assign rd_addr  = (back_sum >= (SW+1)'(TAP_WINDOW)) ?
                    SW'(back_sum - (SW+1)'(TAP_WINDOW)) : SW'(back_sum);

  assign delta     = now_r - rd_data;
  assign gap_over  = delta > STAMP_W'(gap_to_r);
  assign total_inc = (total_r < TW'(CAP)) ? total_r + 1'b1 : total_r;

  assign q_lo    = (div_q < NUM_W'(tmin_r)) ? NUM_W'(tmin_r) : div_q;
  assign q_clamp = (q_lo > NUM_W'(tmax_r)) ? NUM_W'(tmax_r) : q_lo;

  tte_ram #(
    .WIDTH(STAMP_W),
    .DEPTH(TAP_WINDOW)
  ) u_ring (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(slot_r),
    .wr_data(now_r),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  tte_div #(
    .NUM_W(NUM_W),
    .DEN_W(STAMP_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (num_r),
    .den  (delta),
    .quot (div_q),
    .done (div_done)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (total_r != '0) ? S_GAP_RD : S_WRITE;
        end
      end
      S_GAP_RD:    state_nxt = S_GAP_CHK;
      S_GAP_CHK:   state_nxt = S_WRITE;
      S_WRITE:     state_nxt = (total_inc >= TW'(3)) ? S_FIRST_RD : S_DONE;
      S_FIRST_RD:  state_nxt = S_FIRST_CHK;
      S_FIRST_CHK: state_nxt = (delta == '0) ? S_DONE : S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_tready = 1'b0;
    wr_en     = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE:      in_tready = 1'b1;
      S_WRITE:     wr_en     = 1'b1;
      S_FIRST_CHK: div_start = (delta != '0);
      S_DONE:      out_load  = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      slot_r  <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_GAP_CHK && gap_over) begin
        slot_r  <= '0;
        total_r <= '0;
      end else if (state_r == S_WRITE) begin
        slot_r  <= (slot_r == SW'(TAP_WINDOW - 1)) ? '0 : slot_r + 1'b1;
        total_r <= total_inc;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          now_r <= in_tdata;
        end
      end
      S_WRITE: begin
        held_r   <= (total_inc < TW'(TAP_WINDOW)) ? HW'(total_inc) : HW'(TAP_WINDOW);
        status_r <= TS_WAIT;
        bpm_r    <= '0;
      end
      S_FIRST_RD: begin
        num_r <= NUM_W'(32'(BPM_NUM) * 32'(held_r - 1'b1));
      end
      S_FIRST_CHK: begin
        status_r <= TS_ZERO;
        bpm_r    <= '0;
      end
      S_DIV: begin
        if (div_done) begin
          status_r <= TS_TEMPO;
          bpm_r    <= q_clamp[TEMPO_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {1'b0, HELD_W'(held_r), bpm_r, status_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_busy_after_tap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("tap accepted while previous tap still in work");

  a_total_capped: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= TW'(CAP))
    else $error("tap count above its cap");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside divide state");

  a_gap_check_has_history: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_GAP_CHK |-> total_r != '0)
    else $error("gap check without prior tap");

endmodule
